/* src/bfha_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package bfha_pkg;

	// default sizing
	localparam int DEF_MAX_BLOCKS = 64;
	localparam int DEF_ADDR_WIDTH = 32;

	// register reset values
	localparam logic [6:0]  HDR_RESET   = 7'd32;
	localparam logic [31:0] LIMIT_RESET = 32'd1048576;

	// an excess at or above this is never a best fit
	localparam longint FIT_CAP = 64'd2147483647;

	// register indexes
	localparam logic REG_HEADER_SIZE = 1'b0;
	localparam logic REG_HEAP_LIMIT  = 1'b1;

	// operations
	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	// result status
	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_EXHAUSTED  = 2'd1;
	localparam logic [1:0] ST_TABLE_FULL = 2'd2;
	localparam logic [1:0] ST_REJECTED   = 2'd3;

	// table commands broadcast to the row of slots
	localparam logic [1:0] CMD_NOP    = 2'd0;
	localparam logic [1:0] CMD_WRITE  = 2'd1;
	localparam logic [1:0] CMD_INSERT = 2'd2;
	localparam logic [1:0] CMD_REMOVE = 2'd3;

endpackage

`default_nettype wire

/* src/bfha_req_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface bfha_req_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [31:0] req_size;
	logic [31:0] block_address;

	modport source(output valid, func, req_size, block_address, input ready);
	modport sink(input valid, func, req_size, block_address, output ready);
endinterface

`default_nettype wire

/* src/bfha_rsp_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface bfha_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] address;
	logic [1:0]  status;

	modport source(output valid, address, status, input ready);
	modport sink(input valid, address, status, output ready);
endinterface

`default_nettype wire

/* src/bfha_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module bfha_cell import bfha_pkg::*; #(
	parameter int  W   = DEF_ADDR_WIDTH,
	parameter int  LW  = DEF_ADDR_WIDTH + 2,
	parameter int  IW  = 6,
	parameter int  CW  = 7,
	parameter int  IDX = 0,
	parameter type cmd_t = logic,
	parameter type sw_t  = logic
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire cmd_t          cmd,
	input  wire logic [CW-1:0] count,
	input  wire logic [6:0]    hdr,
	input  wire logic [31:0]   size,
	input  wire logic [31:0]   addr,
	input  wire sw_t           sw_in,
	input  wire logic [W-1:0]  prev_start,
	input  wire logic [W-1:0]  prev_len,
	input  wire logic          prev_free,
	input  wire logic [W-1:0]  prev_end,
	input  wire logic [W-1:0]  next_start,
	input  wire logic [W-1:0]  next_len,
	input  wire logic          next_free,
	output logic [W-1:0]       start,
	output logic [W-1:0]       len,
	output logic               free,
	output logic [W-1:0]       end_addr,
	output sw_t                sw_out
);

	localparam logic [IW-1:0] MY_POS   = IW'(IDX);
	localparam logic [CW-1:0] MY_CNT   = CW'(IDX);
	localparam logic [CW-1:0] NEXT_CNT = CW'(IDX + 1);
	localparam logic          HAS_PREV = (IDX != 0);

	logic [W-1:0]  start_q, len_q;
	logic          free_q;
	logic [W-1:0]  payload;
	logic          active, next_active;
	logic [LW-1:0] lenx, sizex, exc;
	sw_t           sw_d, sw_q;

	assign start    = start_q;
	assign len      = len_q;
	assign free     = free_q;
	assign payload  = start_q + W'(hdr);
	assign end_addr = payload + len_q;
	assign sw_out   = sw_q;

	assign active      = MY_CNT < count;
	assign next_active = NEXT_CNT < count;

	// free mark: write, shift up on insert, shift down on remove
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q <= 1'b0;
		end else begin
			case (cmd.op)
				CMD_WRITE: begin
					if (cmd.pos == MY_POS) free_q <= cmd.free;
				end
				CMD_INSERT: begin
					if (MY_POS > cmd.pos) free_q <= prev_free;
					else if (MY_POS == cmd.pos) free_q <= cmd.free;
				end
				CMD_REMOVE: begin
					if (MY_POS >= cmd.pos) free_q <= next_free;
				end
				default: ;
			endcase
		end
	end

	// block start and length follow the same moves
	always_ff @(posedge clk) begin
		case (cmd.op)
			CMD_WRITE: begin
				if (cmd.pos == MY_POS) begin
					start_q <= cmd.start;
					len_q   <= cmd.len;
				end
			end
			CMD_INSERT: begin
				if (MY_POS > cmd.pos) begin
					start_q <= prev_start;
					len_q   <= prev_len;
				end else if (MY_POS == cmd.pos) begin
					start_q <= cmd.start;
					len_q   <= cmd.len;
				end
			end
			CMD_REMOVE: begin
				if (MY_POS >= cmd.pos) begin
					start_q <= next_start;
					len_q   <= next_len;
				end
			end
			default: ;
		endcase
	end

	assign lenx  = LW'(len_q);
	assign sizex = LW'(size);
	assign exc   = lenx - sizex;

	// search word passing through this slot
	always_comb begin
		sw_d = sw_in;
		if (sw_in.go && active) begin
			if (sw_in.func == FUNC_ALLOC) begin
				if (!sw_in.exact && free_q) begin
					if (lenx == sizex) begin
						sw_d.found = 1'b1;
						sw_d.exact = 1'b1;
						sw_d.idx   = MY_POS;
						sw_d.start = start_q;
						sw_d.len   = len_q;
					end else if (lenx > sizex && exc < sw_in.best_exc) begin
						sw_d.found    = 1'b1;
						sw_d.best_exc = exc;
						sw_d.idx      = MY_POS;
						sw_d.start    = start_q;
						sw_d.len      = len_q;
					end
				end
			end else begin
				if (!sw_in.found && !free_q && LW'(payload) == LW'(addr)) begin
					sw_d.found      = 1'b1;
					sw_d.idx        = MY_POS;
					sw_d.start      = start_q;
					sw_d.len        = len_q;
					sw_d.m_next     = next_active && next_free && end_addr == next_start;
					sw_d.m_prev     = HAS_PREV && prev_free && prev_end == start_q;
					sw_d.start_prev = prev_start;
					sw_d.len_prev   = prev_len;
					sw_d.len_next   = next_len;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_q <= '0;
		end else begin
			sw_q <= sw_d;
		end
	end

endmodule

`default_nettype wire

/* src/best_fit_heap_allocator.sv */
// Best-fit heap allocator over an address-ordered table of blocks.
// Channels: req (sink) carries func, req_size and block_address; rsp
// (source) returns address and status, one result item per request item.
// Both use valid/ready; an item moves when both are high at a clock edge.
// Configuration: cfg_we writes cfg_data into header_size (index 0) or
// heap_limit (index 1); write only while no request is in flight.
// The table is a row of MAX_BLOCKS slots. A search word walks the row one
// slot per cycle, passing through each slot's register in turn.
// After the scan an allocate passes through S_ALLOC and, with a split,
// S_SPLIT; a free passes through S_FREE1, then S_FREE2 to merge the next
// neighbor and S_FREE3 and S_FREE4 to merge the previous one; each ends in
// S_DONE. A zero-size allocate skips the scan and is rejected. One request
// is worked at a time, so a new request is taken only once the last is done.
// Table inserts and removals shift the row by one slot, all slots together.
// Reset clears the table, heap top and registers to their defaults.
// The result sits in an output register: a new request is accepted while it
// waits, but the next result is held back until rsp.ready takes the first.
`timescale 1ns / 1ps
`default_nettype none

module best_fit_heap_allocator import bfha_pkg::*; #(
	parameter int MAX_BLOCKS = DEF_MAX_BLOCKS,
	parameter int ADDR_WIDTH = DEF_ADDR_WIDTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [31:0] cfg_data,
	bfha_req_if.sink         req,
	bfha_rsp_if.source       rsp
);

	localparam int W  = ADDR_WIDTH;
	localparam int LW = ((ADDR_WIDTH > 32) ? ADDR_WIDTH : 32) + 2;
	localparam int IW = $clog2(MAX_BLOCKS);
	localparam int CW = $clog2(MAX_BLOCKS + 1);
	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_BLOCKS);
	localparam logic [LW-1:0] ADDR_MASK = LW'({W{1'b1}});

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_SCAN  = 4'd1;
	localparam logic [3:0] S_ALLOC = 4'd2;
	localparam logic [3:0] S_SPLIT = 4'd3;
	localparam logic [3:0] S_FREE1 = 4'd4;
	localparam logic [3:0] S_FREE2 = 4'd5;
	localparam logic [3:0] S_FREE3 = 4'd6;
	localparam logic [3:0] S_FREE4 = 4'd7;
	localparam logic [3:0] S_DONE  = 4'd8;

	typedef struct packed {
		logic [1:0]    op;
		logic [IW-1:0] pos;
		logic [W-1:0]  start;
		logic [W-1:0]  len;
		logic          free;
	} cmd_t;

	typedef struct packed {
		logic          go;
		logic          func;
		logic          found;
		logic          exact;
		logic [IW-1:0] idx;
		logic [LW-1:0] best_exc;
		logic [W-1:0]  start;
		logic [W-1:0]  len;
		logic          m_next;
		logic          m_prev;
		logic [W-1:0]  start_prev;
		logic [W-1:0]  len_prev;
		logic [W-1:0]  len_next;
	} sw_t;

	logic [3:0]    state_q;
	logic          func_q, start_q;
	logic [31:0]   size_q, addr_q;
	sw_t           res_q;
	logic [CW-1:0] count_q;
	logic [W-1:0]  top_q, cur_len_q, raddr_q;
	logic [1:0]    rstat_q;
	logic [6:0]    hdr_q;
	logic [31:0]   limit_q;
	logic          out_valid_q;
	logic [31:0]   out_addr_q;
	logic [1:0]    out_status_q;

	cmd_t          cmd;
	sw_t           sw_init;
	sw_t           sw_w [MAX_BLOCKS+1];
	logic [W-1:0]  start_w [MAX_BLOCKS];
	logic [W-1:0]  len_w [MAX_BLOCKS];
	logic          free_w [MAX_BLOCKS];
	logic [W-1:0]  end_w [MAX_BLOCKS];

	logic [LW-1:0] lenx, sizex, hx, exc, ext_end, limx;
	logic          split, in_acc, out_free, zero_req;
	logic [W-1:0]  grant_addr, merged_next, merged_prev;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_q   <= HDR_RESET;
			limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HEADER_SIZE: hdr_q   <= cfg_data[6:0];
				REG_HEAP_LIMIT:  limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// search word entering the row
	always_comb begin
		sw_init          = '0;
		sw_init.go       = start_q;
		sw_init.func     = func_q;
		sw_init.best_exc = LW'(FIT_CAP);
	end
	assign sw_w[0] = sw_init;

	// row of table slots
	for (genvar k = 0; k < MAX_BLOCKS; k++) begin : g_slot
		logic [W-1:0] p_start, p_len, p_end, n_start, n_len;
		logic         p_free, n_free;
		if (k == 0) begin : g_first
			assign p_start = '0;
			assign p_len   = '0;
			assign p_end   = '0;
			assign p_free  = 1'b0;
		end else begin : g_mid
			assign p_start = start_w[k-1];
			assign p_len   = len_w[k-1];
			assign p_end   = end_w[k-1];
			assign p_free  = free_w[k-1];
		end
		if (k == MAX_BLOCKS - 1) begin : g_last
			assign n_start = '0;
			assign n_len   = '0;
			assign n_free  = 1'b0;
		end else begin : g_inner
			assign n_start = start_w[k+1];
			assign n_len   = len_w[k+1];
			assign n_free  = free_w[k+1];
		end
		bfha_cell #(
			.W(W), .LW(LW), .IW(IW), .CW(CW), .IDX(k),
			.cmd_t(cmd_t), .sw_t(sw_t)
		) u_slot (
			.clk(clk), .arst_n(arst_n), .cmd(cmd), .count(count_q),
			.hdr(hdr_q), .size(size_q), .addr(addr_q), .sw_in(sw_w[k]),
			.prev_start(p_start), .prev_len(p_len), .prev_free(p_free),
			.prev_end(p_end), .next_start(n_start), .next_len(n_len),
			.next_free(n_free), .start(start_w[k]), .len(len_w[k]),
			.free(free_w[k]), .end_addr(end_w[k]), .sw_out(sw_w[k+1])
		);
	end

	// allocation arithmetic
	assign lenx        = LW'(res_q.len);
	assign sizex       = LW'(size_q);
	assign hx          = LW'(hdr_q);
	assign exc         = lenx - sizex;
	assign split       = (exc > hx) && (count_q < CNT_MAX);
	assign grant_addr  = res_q.start + W'(hdr_q);
	assign ext_end     = LW'(top_q) + hx + sizex;
	assign limx        = (LW'(limit_q) < ADDR_MASK) ? LW'(limit_q) : ADDR_MASK;
	assign merged_next = res_q.len + W'(hdr_q) + res_q.len_next;
	assign merged_prev = res_q.len_prev + W'(hdr_q) + cur_len_q;

	assign in_acc    = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign out_free  = !out_valid_q || rsp.ready;
	assign zero_req  = (req.func == FUNC_ALLOC) && (req.req_size == '0);

	// table command for the current step
	always_comb begin
		cmd = '0;
		case (state_q)
			S_ALLOC: begin
				if (res_q.found) begin
					cmd.op    = CMD_WRITE;
					cmd.pos   = res_q.idx;
					cmd.start = res_q.start;
					cmd.len   = split ? W'(size_q) : res_q.len;
					cmd.free  = 1'b0;
				end else if (ext_end <= limx && count_q < CNT_MAX) begin
					cmd.op    = CMD_INSERT;
					cmd.pos   = count_q[IW-1:0];
					cmd.start = top_q;
					cmd.len   = W'(size_q);
					cmd.free  = 1'b0;
				end
			end
			S_SPLIT: begin
				cmd.op    = CMD_INSERT;
				cmd.pos   = res_q.idx + IW'(1);
				cmd.start = grant_addr + W'(size_q);
				cmd.len   = W'(exc - hx);
				cmd.free  = 1'b1;
			end
			S_FREE1: begin
				if (res_q.found) begin
					cmd.op    = CMD_WRITE;
					cmd.pos   = res_q.idx;
					cmd.start = res_q.start;
					cmd.len   = res_q.m_next ? merged_next : res_q.len;
					cmd.free  = 1'b1;
				end
			end
			S_FREE2: begin
				cmd.op  = CMD_REMOVE;
				cmd.pos = res_q.idx + IW'(1);
			end
			S_FREE3: begin
				cmd.op    = CMD_WRITE;
				cmd.pos   = res_q.idx - IW'(1);
				cmd.start = res_q.start_prev;
				cmd.len   = merged_prev;
				cmd.free  = 1'b1;
			end
			S_FREE4: begin
				cmd.op  = CMD_REMOVE;
				cmd.pos = res_q.idx;
			end
			default: ;
		endcase
	end

	// request sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			start_q <= 1'b0;
			count_q <= '0;
			top_q   <= '0;
		end else begin
			start_q <= in_acc && !zero_req;
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (zero_req) begin
							rstat_q <= ST_REJECTED;
							raddr_q <= '0;
							state_q <= S_DONE;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (sw_w[MAX_BLOCKS].go) begin
						res_q   <= sw_w[MAX_BLOCKS];
						state_q <= (func_q == FUNC_ALLOC) ? S_ALLOC : S_FREE1;
					end
				end
				S_ALLOC: begin
					if (res_q.found) begin
						rstat_q <= ST_OK;
						raddr_q <= grant_addr;
						state_q <= split ? S_SPLIT : S_DONE;
					end else if (ext_end > limx) begin
						rstat_q <= ST_EXHAUSTED;
						raddr_q <= '0;
						state_q <= S_DONE;
					end else if (count_q >= CNT_MAX) begin
						rstat_q <= ST_TABLE_FULL;
						raddr_q <= '0;
						state_q <= S_DONE;
					end else begin
						rstat_q <= ST_OK;
						raddr_q <= top_q + W'(hdr_q);
						top_q   <= W'(ext_end);
						count_q <= count_q + CW'(1);
						state_q <= S_DONE;
					end
				end
				S_SPLIT: begin
					count_q <= count_q + CW'(1);
					state_q <= S_DONE;
				end
				S_FREE1: begin
					raddr_q   <= '0;
					cur_len_q <= res_q.m_next ? merged_next : res_q.len;
					if (!res_q.found) begin
						rstat_q <= ST_REJECTED;
						state_q <= S_DONE;
					end else begin
						rstat_q <= ST_OK;
						if (res_q.m_next) state_q <= S_FREE2;
						else if (res_q.m_prev) state_q <= S_FREE3;
						else state_q <= S_DONE;
					end
				end
				S_FREE2: begin
					count_q <= count_q - CW'(1);
					state_q <= res_q.m_prev ? S_FREE3 : S_DONE;
				end
				S_FREE3: begin
					state_q <= S_FREE4;
				end
				S_FREE4: begin
					count_q <= count_q - CW'(1);
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// request operands
	always_ff @(posedge clk) begin
		if (in_acc) begin
			func_q <= req.func;
			size_q <= req.req_size;
			addr_q <= req.block_address;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			out_addr_q   <= 32'(LW'(raddr_q));
			out_status_q <= rstat_q;
		end
	end

	assign rsp.valid   = out_valid_q;
	assign rsp.address = out_addr_q;
	assign rsp.status  = out_status_q;

endmodule

`default_nettype wire

/* dv/tb_best_fit_heap_allocator.sv */
`timescale 1ns / 1ps

module tb_best_fit_heap_allocator;
	import bfha_pkg::*;

	localparam int NBLK = DEF_MAX_BLOCKS;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SETTLE_CYCLES = NBLK + 16;

	typedef struct {
		logic        func;
		logic [31:0] req_size;
		logic [31:0] block_address;
	} heap_req_t;

	typedef struct {
		logic [31:0] address;
		logic [1:0]  status;
	} heap_rsp_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [31:0] cfg_data;

	bfha_req_if req ();
	bfha_rsp_if rsp ();

	best_fit_heap_allocator u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req.sink),
		.rsp       (rsp.source)
	);

	// pending requests and predicted responses
	heap_req_t pending_reqs[$];
	heap_rsp_t grant_q[$];

	int errors = 0;
	int stall_cycles = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit req_taken = 0;

	// allocator shadow state
	longint unsigned hdr_size;
	longint unsigned top_limit;
	longint unsigned blk_start[NBLK];
	longint unsigned blk_len[NBLK];
	bit              blk_free[NBLK];
	int              blk_count;
	longint unsigned heap_top;

	localparam longint unsigned ADDR_MASK = 64'hFFFF_FFFF;

	// clock
	initial clk = 0;
	always #6 clk = ~clk;

	function automatic void table_insert(int pos, longint unsigned start,
			longint unsigned len, bit fr);
		if (blk_count >= NBLK || pos > blk_count)
			return;
		for (int k = blk_count; k > pos; k--) begin
			blk_start[k] = blk_start[k-1];
			blk_len[k] = blk_len[k-1];
			blk_free[k] = blk_free[k-1];
		end
		blk_start[pos] = start;
		blk_len[pos] = len;
		blk_free[pos] = fr;
		blk_count++;
	endfunction

	function automatic void table_remove(int pos);
		if (pos >= blk_count)
			return;
		for (int k = pos; k + 1 < blk_count; k++) begin
			blk_start[k] = blk_start[k+1];
			blk_len[k] = blk_len[k+1];
			blk_free[k] = blk_free[k+1];
		end
		blk_count--;
	endfunction

	function automatic bit adjacent(int lo, int hi);
		return ((blk_start[lo] + hdr_size + blk_len[lo]) & ADDR_MASK) == blk_start[hi];
	endfunction

	// best-fit search, split or bump of the heap top
	function automatic logic [1:0] alloc_block(longint unsigned size,
			output logic [31:0] grant);
		int best;
		longint unsigned best_excess;
		longint unsigned cap;
		longint unsigned len;
		longint unsigned lim;
		longint unsigned stop;
		best = -1;
		cap = FIT_CAP;
		best_excess = cap;
		grant = '0;
		if (size == 0)
			return ST_REJECTED;
		for (int i = 0; i < blk_count; i++) begin
			if (!blk_free[i])
				continue;
			if (blk_len[i] == size) begin
				best = i;
				break;
			end
			if (blk_len[i] > size && blk_len[i] - size < best_excess) begin
				best_excess = blk_len[i] - size;
				best = i;
			end
		end
		if (best >= 0) begin
			len = blk_len[best];
			blk_free[best] = 0;
			if (len - size > hdr_size && blk_count < NBLK) begin
				blk_len[best] = size;
				table_insert(best + 1, (blk_start[best] + hdr_size + size) & ADDR_MASK,
					len - size - hdr_size, 1);
			end
			grant = 32'((blk_start[best] + hdr_size) & ADDR_MASK);
			return ST_OK;
		end
		lim = top_limit < ADDR_MASK ? top_limit : ADDR_MASK;
		stop = heap_top + hdr_size + size;
		if (stop > lim)
			return ST_EXHAUSTED;
		if (blk_count >= NBLK)
			return ST_TABLE_FULL;
		table_insert(blk_count, heap_top, size, 0);
		grant = 32'((heap_top + hdr_size) & ADDR_MASK);
		heap_top = stop;
		return ST_OK;
	endfunction

	// release and merge with free physical neighbors
	function automatic logic [1:0] release_block(longint unsigned addr);
		int i;
		for (i = 0; i < blk_count; i++)
			if (!blk_free[i] && ((blk_start[i] + hdr_size) & ADDR_MASK) == addr)
				break;
		if (i >= blk_count)
			return ST_REJECTED;
		blk_free[i] = 1;
		if (i + 1 < blk_count && blk_free[i+1] && adjacent(i, i + 1)) begin
			blk_len[i] += hdr_size + blk_len[i+1];
			table_remove(i + 1);
		end
		if (i > 0 && blk_free[i-1] && adjacent(i - 1, i)) begin
			blk_len[i-1] += hdr_size + blk_len[i];
			table_remove(i);
		end
		return ST_OK;
	endfunction

	// predict the response and queue the item
	task automatic send_item(logic func, logic [31:0] size, logic [31:0] addr);
		heap_req_t it;
		heap_rsp_t r;
		it.func = func;
		it.req_size = size;
		it.block_address = addr;
		r.address = '0;
		if (func == FUNC_ALLOC)
			r.status = alloc_block(size, r.address);
		else
			r.status = release_block(addr);
		if (r.status != ST_OK)
			r.address = '0;
		pending_reqs.push_back(it);
		grant_q.push_back(r);
	endtask

	// payload address of a random live block, or noise if none
	function automatic logic [31:0] live_address();
		int idx[$];
		for (int i = 0; i < blk_count; i++)
			if (!blk_free[i])
				idx.push_back(i);
		if (idx.size() == 0)
			return $urandom();
		return 32'((blk_start[idx[$urandom_range(0, idx.size() - 1)]] + hdr_size) & ADDR_MASK);
	endfunction

	task automatic write_reg(logic idx, logic [31:0] value);
		@(negedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 0;
		if (idx == REG_HEADER_SIZE)
			hdr_size = value & 32'h7F;
		else
			top_limit = value;
	endtask

	task automatic drain();
		wait (pending_reqs.size() == 0 && grant_q.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic random_items(int n);
		int roll;
		for (int k = 0; k < n; k++) begin
			roll = $urandom_range(0, 99);
			if (roll < 52)
				send_item(FUNC_ALLOC, $urandom_range(1, 256), $urandom());
			else if (roll < 57)
				send_item(FUNC_ALLOC, $urandom_range(0, 3) == 0 ? 0 : $urandom(), $urandom());
			else if (roll < 94)
				send_item(FUNC_FREE, $urandom(), live_address());
			else
				send_item(FUNC_FREE, $urandom(), $urandom());
		end
	endtask

	// request driver
	always @(negedge clk) begin
		if (!arst_n) begin
			req.valid <= 0;
		end else if (req.valid && !req_taken) begin
			req.valid <= 1;
		end else if (pending_reqs.size() > 0 &&
				$urandom_range(0, 99) >= send_idle_pct) begin
			req.valid <= 1;
			req.func <= pending_reqs[0].func;
			req.req_size <= pending_reqs[0].req_size;
			req.block_address <= pending_reqs[0].block_address;
		end else begin
			req.valid <= 0;
		end
		rsp.ready <= arst_n && ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// monitor and watchdog
	always @(posedge clk) begin
		heap_rsp_t e;
		req_taken = req.valid && req.ready;
		if (req_taken)
			void'(pending_reqs.pop_front());
		if (rsp.valid && rsp.ready) begin
			if (grant_q.size() == 0) begin
				$error("unexpected item: address %h status %0d", rsp.address, rsp.status);
				errors++;
			end else begin
				e = grant_q.pop_front();
				if (rsp.address !== e.address) begin
					$error("address: expected %h actual %h", e.address, rsp.address);
					errors++;
				end
				if (rsp.status !== e.status) begin
					$error("status: expected %0d actual %0d", e.status, rsp.status);
					errors++;
				end
			end
		end
		if (req_taken || (rsp.valid && rsp.ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("** best_fit_heap_allocator: FAILED **");
			$finish;
		end
	end

	initial begin
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		arst_n = 0;
		cfg_we = 0;
		cfg_index = REG_HEADER_SIZE;
		cfg_data = '0;
		req.valid = 0;
		req.func = FUNC_ALLOC;
		req.req_size = '0;
		req.block_address = '0;
		rsp.ready = 0;
		hdr_size = HDR_RESET;
		top_limit = LIMIT_RESET;
		blk_count = 0;
		heap_top = 0;
		for (int k = 0; k < NBLK; k++) begin
			blk_start[k] = 0;
			blk_len[k] = 0;
			blk_free[k] = 0;
		end
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: rejects, exhaustion, split, exact fit, merges
		send_item(FUNC_ALLOC, 0, 32'hFFFF_FFFF);
		send_item(FUNC_FREE, 32'hFFFF_FFFF, 0);
		send_item(FUNC_ALLOC, 32'hFFFF_FFFF, 0);
		send_item(FUNC_ALLOC, 1, 0);
		a = live_address();
		send_item(FUNC_ALLOC, 200, 0);
		b = 32'((blk_start[blk_count-1] + hdr_size) & ADDR_MASK);
		send_item(FUNC_ALLOC, 64, 0);
		c = 32'((blk_start[blk_count-1] + hdr_size) & ADDR_MASK);
		send_item(FUNC_ALLOC, 16, 0);
		send_item(FUNC_FREE, 0, b);
		send_item(FUNC_FREE, 0, b);
		send_item(FUNC_ALLOC, 200, 0);
		send_item(FUNC_FREE, 0, b);
		send_item(FUNC_ALLOC, 50, 0);
		send_item(FUNC_FREE, 0, a);
		send_item(FUNC_FREE, 0, c);
		send_item(FUNC_FREE, 0, live_address());
		send_item(FUNC_ALLOC, 190, 0);
		send_item(FUNC_ALLOC, 180, 0);
		send_item(FUNC_FREE, 0, 32'h8000_0000);

		for (int phase = 0; phase < 6; phase++) begin
			send_idle_pct = phase < 2 ? 8 : (phase < 4 ? 66 : 0);
			recv_idle_pct = phase < 2 ? 66 : (phase < 4 ? 8 : 0);
			drain();
			case (phase)
				1: begin
					write_reg(REG_HEADER_SIZE, 0);
					write_reg(REG_HEAP_LIMIT, 32'hFFFF_FFFF);
					// excess too large to ever be a best fit
					send_item(FUNC_ALLOC, 32'hC000_0000, 0);
					a = 32'((blk_start[blk_count-1] + hdr_size) & ADDR_MASK);
					send_item(FUNC_FREE, 0, a);
					send_item(FUNC_ALLOC, 1, 0);
					send_item(FUNC_ALLOC, 32'hC000_0000, 0);
				end
				2: begin
					write_reg(REG_HEADER_SIZE, 64);
					write_reg(REG_HEAP_LIMIT, 32'hFFFF_FFFF);
					// fill the table, then split and extension with it full
					while (blk_count < NBLK)
						send_item(FUNC_ALLOC, 300, 0);
					send_item(FUNC_ALLOC, 8, 0);
					send_item(FUNC_FREE, 0, live_address());
					send_item(FUNC_ALLOC, 8, 0);
					send_item(FUNC_ALLOC, 500, 0);
				end
				3: begin
					write_reg(REG_HEADER_SIZE, 17);
					write_reg(REG_HEAP_LIMIT, 0);
				end
				4: begin
					write_reg(REG_HEADER_SIZE, 64);
					write_reg(REG_HEAP_LIMIT, 32'h0004_0000);
				end
				5: begin
					write_reg(REG_HEADER_SIZE, 5);
					write_reg(REG_HEAP_LIMIT, 32'hFFFF_FFFF);
				end
				default: ;
			endcase
			random_items(170);
		end
		drain();
		if (errors == 0)
			$display("** best_fit_heap_allocator: PASSED **");
		else
			$display("** best_fit_heap_allocator: FAILED **");
		$finish;
	end

endmodule

/* files.f */
src/bfha_pkg.sv
src/bfha_req_if.sv
src/bfha_rsp_if.sv
src/bfha_cell.sv
src/best_fit_heap_allocator.sv
dv/tb_best_fit_heap_allocator.sv
